FILE: rtl/core/imu_fa_pkg.sv
`default_nettype none

package imu_fa_pkg;

   localparam int unsigned NormalLen = 19;
   localparam int unsigned ExtLen    = 23;
   localparam int unsigned FrameLen  = 3 * NormalLen + ExtLen;

   localparam int unsigned PosW = 7;

   localparam logic [PosW-1:0] SUB1_START = PosW'(NormalLen);
   localparam logic [PosW-1:0] SUB2_START = PosW'(2 * NormalLen);
   localparam logic [PosW-1:0] SUB3_START = PosW'(3 * NormalLen);
   localparam logic [PosW-1:0] FRAME_END  = PosW'(FrameLen);
   localparam logic [PosW-1:0] LEN_NORMAL = PosW'(NormalLen);
   localparam logic [PosW-1:0] LEN_EXT    = PosW'(ExtLen);
   localparam logic [PosW-1:0] REG_ID_OFS = PosW'(3);

   localparam logic [7:0] HEADER_RESET = 8'd85;
   localparam logic [7:0] TAIL_RESET   = 8'd170;

   localparam logic [7:0] REG_ID_SUB0 = 8'd1;
   localparam logic [7:0] REG_ID_SUB1 = 8'd2;
   localparam logic [7:0] REG_ID_SUB2 = 8'd3;
   localparam logic [7:0] REG_ID_SUB3 = 8'd4;

   typedef enum logic {
      CSR_HEADER = 1'b0,
      CSR_TAIL   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic            kept;
      logic [PosW-1:0] position;
      logic [7:0]      byte_out;
      logic            frame_done;
      logic            frame_dropped;
   } result_type;

endpackage

`default_nettype wire

FILE: rtl/core/imu_fa_in_stage.sv
`default_nettype none

module imu_fa_in_stage (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       out_ready,
   output logic            s0_valid,
   output logic [7:0]      s0_byte
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       load;

   // stage drains whenever the result side can take its item
   assign req_stall = valid_ff & ~out_ready;
   assign load      = req_valid & ~req_stall;
   assign valid_in  = req_stall ? valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign s0_valid = valid_ff;
   assign s0_byte  = byte_ff;

endmodule

`default_nettype wire

FILE: rtl/core/imu_fa_assemble.sv
`default_nettype none

module imu_fa_assemble (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      step,
   input  wire logic [7:0]                rx_byte,
   input  wire logic [7:0]                header_value,
   input  wire logic [7:0]                tail_value,
   output imu_fa_pkg::result_type         result
);

   logic [imu_fa_pkg::PosW-1:0] fill_ff, fill_in;
   logic                        swh_ff, swh_in;
   logic                        rim_ff, rim_in;

   logic                        is_hdr;
   logic [imu_fa_pkg::PosW-1:0] sub_start, sub_len, sub_end, fill_next;
   logic [7:0]                  reg_id;
   logic                        ok;

   assign is_hdr = (rx_byte == header_value);

   always_comb begin
      if (fill_ff < imu_fa_pkg::SUB1_START) begin
         sub_start = '0;
         sub_len   = imu_fa_pkg::LEN_NORMAL;
         reg_id    = imu_fa_pkg::REG_ID_SUB0;
      end else if (fill_ff < imu_fa_pkg::SUB2_START) begin
         sub_start = imu_fa_pkg::SUB1_START;
         sub_len   = imu_fa_pkg::LEN_NORMAL;
         reg_id    = imu_fa_pkg::REG_ID_SUB1;
      end else if (fill_ff < imu_fa_pkg::SUB3_START) begin
         sub_start = imu_fa_pkg::SUB2_START;
         sub_len   = imu_fa_pkg::LEN_NORMAL;
         reg_id    = imu_fa_pkg::REG_ID_SUB2;
      end else begin
         sub_start = imu_fa_pkg::SUB3_START;
         sub_len   = imu_fa_pkg::LEN_EXT;
         reg_id    = imu_fa_pkg::REG_ID_SUB3;
      end
   end

   assign sub_end   = sub_start + sub_len;
   assign fill_next = fill_ff + imu_fa_pkg::PosW'(1);

   always_comb begin
      fill_in = fill_ff;
      swh_in  = swh_ff;
      rim_in  = rim_ff;
      ok      = 1'b0;
      result  = '0;
      result.byte_out = rx_byte;

      if (fill_ff != '0 || is_hdr) begin
         if (fill_ff == sub_start) begin
            swh_in = is_hdr;
            rim_in = 1'b0;
         end
         if (fill_ff == sub_start + imu_fa_pkg::REG_ID_OFS) begin
            rim_in = (rx_byte == reg_id);
         end
         result.kept     = 1'b1;
         result.position = fill_ff;
         fill_in         = fill_next;

         if (fill_next == sub_end) begin
            ok = swh_in & rim_in & (rx_byte == tail_value);
            if (!ok) begin
               // failed check: a header byte restarts the frame at offset 0
               result.frame_dropped = 1'b1;
               result.position      = '0;
               rim_in               = 1'b0;
               result.kept          = is_hdr;
               swh_in               = is_hdr;
               fill_in              = is_hdr ? imu_fa_pkg::PosW'(1) : '0;
            end else if (fill_next == imu_fa_pkg::FRAME_END) begin
               result.frame_done = 1'b1;
               fill_in           = '0;
               swh_in            = 1'b0;
               rim_in            = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         swh_ff  <= 1'b0;
         rim_ff  <= 1'b0;
      end else if (step) begin
         fill_ff <= fill_in;
         swh_ff  <= swh_in;
         rim_ff  <= rim_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/imu_frame_assembler_core.sv
// Path: a byte taken on a req transfer loads the input register and then the
// result register, where rsp_valid rises. Throughput: one byte per cycle
// unless rsp_stall holds a result; the assembly state updates in one pass.
// Reset (synchronous, active high): pipeline empty, assembler idle,
// header_value = 85, tail_value = 170.
`default_nettype none

module imu_frame_assembler_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_kept,
   output logic [6:0]      rsp_position,
   output logic [7:0]      rsp_byte_out,
   output logic            rsp_frame_done,
   output logic            rsp_frame_dropped,
   input  wire logic       csr_write,
   input  wire logic       csr_index,
   input  wire logic [7:0] csr_wdata
);

   logic [7:0]             header_ff, tail_ff;
   logic                   out_valid_ff, out_valid_in;
   imu_fa_pkg::result_type out_ff, step_result;
   logic                   out_ready;
   logic                   s0_valid;
   logic [7:0]             s0_byte;
   logic                   step;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= imu_fa_pkg::HEADER_RESET;
         tail_ff   <= imu_fa_pkg::TAIL_RESET;
      end else if (csr_write) begin
         case (imu_fa_pkg::csr_index_type'(csr_index))
            imu_fa_pkg::CSR_HEADER: header_ff <= csr_wdata;
            imu_fa_pkg::CSR_TAIL:   tail_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign out_ready = ~out_valid_ff | ~rsp_stall;
   assign step      = s0_valid & out_ready;

   imu_fa_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .out_ready   (out_ready),
      .s0_valid    (s0_valid),
      .s0_byte     (s0_byte)
   );

   imu_fa_assemble u_assemble (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .rx_byte      (s0_byte),
      .header_value (header_ff),
      .tail_value   (tail_ff),
      .result       (step_result)
   );

   assign out_valid_in = out_ready ? s0_valid : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_kept          = out_ff.kept;
   assign rsp_position      = out_ff.position;
   assign rsp_byte_out      = out_ff.byte_out;
   assign rsp_frame_done    = out_ff.frame_done;
   assign rsp_frame_dropped = out_ff.frame_dropped;

   a_done_xor_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_frame_done && rsp_frame_dropped))
      else $error("frame done and dropped on the same byte");

   a_unkept_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_kept) |-> (rsp_position == '0))
      else $error("position set on a byte that was not kept");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_done) |->
         (rsp_kept && rsp_position == imu_fa_pkg::FRAME_END - imu_fa_pkg::PosW'(1)))
      else $error("frame done away from the last frame offset");

   a_no_step_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(rsp_position) && $stable(rsp_kept)))
      else $error("result changed while held by the receiver");

endmodule

`default_nettype wire
